>>> rtl/xor_checksum_packet_deframer_assert.svh
// Assertion macros for the XOR checksum packet deframer.
// Used by modules that clock on clk_i and reset on rst_ni; no other dependencies.
`ifndef XOR_CHECKSUM_PACKET_DEFRAMER_ASSERT_SVH
`define XOR_CHECKSUM_PACKET_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// Property holds on every clock edge outside reset.
`define XCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define XCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define XCD_ASSERT(lbl, prop, msg)
`define XCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/xcd_pkg.sv
// Shared types and constants of the XOR checksum packet deframer.
// No dependencies.
package xcd_pkg;

  localparam int unsigned MaxPayload = 32;
  localparam int unsigned BufAddrW   = $clog2(MaxPayload);
  localparam int unsigned LenW       = 6;
  localparam int unsigned TicksW     = 17;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 17;

  localparam logic [7:0]        MarkerReset  = 8'hAA;
  localparam logic [TicksW-1:0] TimeoutReset = 17'd100000;

  typedef enum logic [2:0] {
    S_START,
    S_LENGTH,
    S_PAYLOAD,
    S_CHECK,
    S_DRAIN
  } xcd_state_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_START = 3'd1,
    STAT_BAD_CHECK = 3'd2,
    STAT_TIMEOUT   = 3'd3,
    STAT_TOO_LONG  = 3'd4
  } xcd_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MARKER = 1'b0,
    CFG_TIMEOUT      = 1'b1
  } xcd_cfg_e;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } xcd_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [LenW-1:0] packet_length;
    logic [7:0]      data_byte;
    logic [4:0]      byte_index;
    logic            last;
  } xcd_out_t;

  typedef struct packed {
    logic                we;
    logic [BufAddrW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [BufAddrW-1:0] raddr;
  } xcd_mem_req_t;

endpackage

>>> rtl/xor_checksum_packet_deframer.sv
// Top level of the XOR checksum packet deframer.
// Depends on xcd_pkg, xcd_buf and xcd_ctrl.

// Deframes start/length/payload/checksum packets from a stream of words, each
// either a received byte or one time tick. While the block is receiving, it
// takes one input word per cycle whenever its result register is free, and a
// word causes at most one result. A packet whose checksum matches is then
// played out of the payload buffer one byte per cycle while the result
// register is free: the read for byte k+1 is issued in the same cycle byte k
// is loaded into the result register, and input is held off until the last
// byte is loaded. The single-port read of the payload buffer sets that drain
// rate. Errors (bad start, length too large, checksum mismatch, timeout) each
// give one result with last set and restart the frame. The payload buffer has
// no reset; every entry that is played out is written before it is read, and
// reads and writes never target the buffer in the same cycle, so no
// forwarding is needed. Config writes are meant for idle periods; a new
// timeout value takes effect at the next reload of the tick counter.
module xor_checksum_packet_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xcd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [xcd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  xcd_pkg::xcd_in_t              in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output xcd_pkg::xcd_out_t             out_word_o
);
  import xcd_pkg::*;

  xcd_mem_req_t mem_req;
  logic [7:0]   mem_rd_data;

  // frame FSM, timeout counter and result register
  xcd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_word_i     (in_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_word_o    (out_word_o),
    .mem_req_o     (mem_req),
    .mem_rd_data_i (mem_rd_data)
  );

  // payload storage, registered read data
  xcd_buf u_buf (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

endmodule

>>> rtl/xcd_buf.sv
// Payload buffer: one write port, one read port, registered read data.
// Depends on xcd_pkg for depth and request struct.
module xcd_buf (
  input  logic                  clk_i,
  input  xcd_pkg::xcd_mem_req_t req_i,
  output logic [7:0]            rd_data_o
);
  import xcd_pkg::*;

  logic [7:0] mem_q [MaxPayload];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_o <= mem_q[req_i.raddr];
    end
  end

endmodule

>>> rtl/xcd_ctrl.sv
// Frame sequencer: config registers, timeout counter, frame FSM, drain and result register.
// Depends on xcd_pkg and the assertion macro header; drives the payload buffer.
module xcd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xcd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [xcd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  xcd_pkg::xcd_in_t              in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output xcd_pkg::xcd_out_t             out_word_o,
  output xcd_pkg::xcd_mem_req_t         mem_req_o,
  input  logic [7:0]                    mem_rd_data_i
);
  import xcd_pkg::*;

  `include "xor_checksum_packet_deframer_assert.svh"

  logic [7:0]          marker_q;
  logic [TicksW-1:0]   timeout_q;
  xcd_state_e          state_q, state_d;
  logic [TicksW-1:0]   ticks_q, ticks_d;
  logic [LenW-1:0]     exp_len_q, exp_len_d;
  logic [LenW-1:0]     cnt_q, cnt_d;
  logic [7:0]          xor_q, xor_d;
  logic [BufAddrW-1:0] drain_idx_q, drain_idx_d;
  logic                out_valid_q, out_valid_d;
  xcd_out_t            out_q;

  logic       out_free, in_acc, drain_go, drain_last, res_vld;
  logic [7:0] rx;
  logic [LenW-1:0] cnt_inc;
  xcd_out_t   res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q != S_DRAIN) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign drain_go   = (state_q == S_DRAIN) && out_free;
  assign rx         = in_word_i.rx_byte;
  assign cnt_inc    = cnt_q + LenW'(1);
  assign drain_last = (LenW'(drain_idx_q) + LenW'(1)) == exp_len_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q  <= MarkerReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_MARKER: marker_q  <= cfg_data_i[7:0];
        CFG_TIMEOUT:      timeout_q <= cfg_data_i[TicksW-1:0];
        default:          ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d     = state_q;
    ticks_d     = ticks_q;
    exp_len_d   = exp_len_q;
    cnt_d       = cnt_q;
    xor_d       = xor_q;
    drain_idx_d = drain_idx_q;
    if (in_acc) begin
      if (in_word_i.func) begin
        if (ticks_q <= TicksW'(1)) begin
          ticks_d = timeout_q;
          state_d = S_START;
        end else begin
          ticks_d = ticks_q - TicksW'(1);
        end
      end else begin
        ticks_d = timeout_q;
        case (state_q)
          S_START: begin
            if (rx == marker_q) state_d = S_LENGTH;
          end
          S_LENGTH: begin
            if (rx > 8'(MaxPayload)) begin
              state_d = S_START;
            end else begin
              exp_len_d = rx[LenW-1:0];
              xor_d     = rx;
              cnt_d     = '0;
              state_d   = (rx == 8'd0) ? S_CHECK : S_PAYLOAD;
            end
          end
          S_PAYLOAD: begin
            xor_d = xor_q ^ rx;
            cnt_d = cnt_inc;
            if (cnt_inc >= exp_len_q) state_d = S_CHECK;
          end
          S_CHECK: begin
            if (rx != xor_q || exp_len_q == '0) begin
              state_d = S_START;
            end else begin
              state_d     = S_DRAIN;
              drain_idx_d = '0;
            end
          end
          default: state_d = state_q;
        endcase
      end
    end
    if (drain_go) begin
      if (drain_last) state_d = S_START;
      else            drain_idx_d = drain_idx_q + BufAddrW'(1);
    end
  end

  // result word and buffer access
  always_comb begin
    res        = '0;
    res.last   = 1'b1;
    res_vld    = 1'b0;
    mem_req_o  = '0;
    if (in_acc) begin
      if (in_word_i.func) begin
        if (ticks_q <= TicksW'(1)) begin
          res_vld    = 1'b1;
          res.status = STAT_TIMEOUT;
        end
      end else begin
        case (state_q)
          S_START: begin
            if (rx != marker_q) begin
              res_vld    = 1'b1;
              res.status = STAT_BAD_START;
            end
          end
          S_LENGTH: begin
            if (rx > 8'(MaxPayload)) begin
              res_vld    = 1'b1;
              res.status = STAT_TOO_LONG;
            end
          end
          S_PAYLOAD: begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = cnt_q[BufAddrW-1:0];
            mem_req_o.wdata = rx;
          end
          S_CHECK: begin
            if (rx != xor_q) begin
              res_vld    = 1'b1;
              res.status = STAT_BAD_CHECK;
            end else if (exp_len_q == '0) begin
              res_vld    = 1'b1;
              res.status = STAT_OK;
            end else begin
              // prefetch byte 0 for the drain
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = '0;
            end
          end
          default: ;
        endcase
      end
    end
    if (drain_go) begin
      res_vld           = 1'b1;
      res.status        = STAT_OK;
      res.packet_length = exp_len_q;
      res.data_byte     = mem_rd_data_i;
      res.byte_index    = 5'(drain_idx_q);
      res.last          = drain_last;
      mem_req_o.re      = 1'b1;
      mem_req_o.raddr   = drain_idx_q + BufAddrW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_vld)          out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_START;
      ticks_q     <= TimeoutReset;
      exp_len_q   <= '0;
      cnt_q       <= '0;
      xor_q       <= '0;
      drain_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ticks_q     <= ticks_d;
      exp_len_q   <= exp_len_d;
      cnt_q       <= cnt_d;
      xor_q       <= xor_d;
      drain_idx_q <= drain_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `XCD_ASSERT(a_drain_in_range, (state_q != S_DRAIN) || (LenW'(drain_idx_q) < exp_len_q), "drain index past packet length")
  `XCD_ASSERT(a_payload_in_range, (state_q != S_PAYLOAD) || (cnt_q < exp_len_q), "payload count past expected length")
  `XCD_ASSERT_NEXT(a_drain_ends, drain_go && drain_last, (state_q == S_START) && out_valid_q && out_q.last, "drain did not close on last byte")

endmodule

>>> sim/deframer_checker.sv
// Result checker for the XOR checksum packet deframer: follows config writes, predicts
// the result words of every accepted input word and compares them in arrival order.
// Depends on xcd_pkg.
module deframer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xcd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [xcd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  xcd_pkg::xcd_in_t              in_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  xcd_pkg::xcd_out_t             out_word_i,
  output int                            fail_count_o,
  output int                            outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import xcd_pkg::*;

  typedef enum logic [1:0] {
    RX_MARKER,
    RX_LENGTH,
    RX_PAYLOAD,
    RX_CHECKSUM
  } rx_phase_e;

  rx_phase_e         rx_phase;
  logic [5:0]        frame_len;
  logic [5:0]        bytes_seen;
  logic [7:0]        check_acc;
  logic [7:0]        marker_cfg;
  logic [TicksW-1:0] timeout_cfg;
  logic [TicksW-1:0] ticks_left;
  logic [7:0]        payload_buf [MaxPayload];
  xcd_out_t          pending_results [$];
  int                fails;

  task automatic push_error(input xcd_status_e st);
    xcd_out_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    pending_results.push_back(r);
    rx_phase = RX_MARKER;
  endtask

  task automatic deframe_word(input xcd_in_t w);
    xcd_out_t r;
    if (w.func) begin
      if (ticks_left <= 17'd1) begin
        ticks_left = timeout_cfg;
        push_error(STAT_TIMEOUT);
      end else begin
        ticks_left = ticks_left - 1'b1;
      end
      return;
    end
    ticks_left = timeout_cfg;
    case (rx_phase)
      RX_MARKER: begin
        if (w.rx_byte != marker_cfg) push_error(STAT_BAD_START);
        else rx_phase = RX_LENGTH;
      end
      RX_LENGTH: begin
        if (w.rx_byte > MaxPayload) begin
          push_error(STAT_TOO_LONG);
        end else begin
          frame_len = w.rx_byte[5:0];
          check_acc = w.rx_byte;
          bytes_seen = '0;
          rx_phase = (w.rx_byte == 8'd0) ? RX_CHECKSUM : RX_PAYLOAD;
        end
      end
      RX_PAYLOAD: begin
        payload_buf[bytes_seen[4:0]] = w.rx_byte;
        check_acc ^= w.rx_byte;
        bytes_seen++;
        if (bytes_seen >= frame_len) rx_phase = RX_CHECKSUM;
      end
      default: begin
        if (w.rx_byte != check_acc) begin
          push_error(STAT_BAD_CHECK);
        end else begin
          rx_phase = RX_MARKER;
          // an empty packet still reports one OK word
          if (frame_len == 6'd0) begin
            r = '0;
            r.status = STAT_OK;
            r.last = 1'b1;
            pending_results.push_back(r);
          end
          for (int k = 0; k < frame_len; k++) begin
            r.status = STAT_OK;
            r.packet_length = frame_len;
            r.data_byte = payload_buf[k];
            r.byte_index = k[4:0];
            r.last = (k == frame_len - 1);
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xcd_out_t want;
    if (!rst_ni) begin
      rx_phase = RX_MARKER;
      frame_len = '0;
      bytes_seen = '0;
      check_acc = '0;
      marker_cfg = MarkerReset;
      timeout_cfg = TimeoutReset;
      ticks_left = TimeoutReset;
      pending_results.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word st=%0d len=%0d data=%02h idx=%0d last=%0b",
                   $time, out_word_i.status, out_word_i.packet_length,
                   out_word_i.data_byte, out_word_i.byte_index, out_word_i.last);
        end else begin
          want = pending_results.pop_front();
          if (out_word_i.status !== want.status ||
              out_word_i.packet_length !== want.packet_length ||
              out_word_i.data_byte !== want.data_byte ||
              out_word_i.byte_index !== want.byte_index ||
              out_word_i.last !== want.last) begin
            fails++;
            // fields: status/length/data/index/last
            $display("%0t: mismatch, expected %0d/%0d/%02h/%0d/%0b actual %0d/%0d/%02h/%0d/%0b",
                     $time, want.status, want.packet_length, want.data_byte,
                     want.byte_index, want.last, out_word_i.status,
                     out_word_i.packet_length, out_word_i.data_byte,
                     out_word_i.byte_index, out_word_i.last);
          end
        end
      end
      // a new timeout only lands in ticks_left at the next reload
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_MARKER: marker_cfg = cfg_data_i[7:0];
          CFG_TIMEOUT:      timeout_cfg = cfg_data_i[TicksW-1:0];
          default:          ;
        endcase
      end
      if (in_valid_i && in_ready_i) deframe_word(in_word_i);
    end
    fail_count_o <= fails;
    outstanding_o <= pending_results.size();
  end

endmodule

>>> sim/tb_xor_checksum_packet_deframer.sv
// Testbench top for the XOR checksum packet deframer: drives reset, config and input
// words, stalls the output side, and gives the verdict from deframer_checker's count.
// Depends on xcd_pkg, deframer_checker and the deframer RTL.
module tb_xor_checksum_packet_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import xcd_pkg::*;

  // Cycle limit for the whole run, with a wide margin over the slowest sane run.
  localparam int CycleLimit = 400000;
  // Cycles allowed after the last expected word for anything still in flight.
  localparam int DrainWait  = 16;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = CFG_START_MARKER;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  xcd_in_t             in_word   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  xcd_out_t            out_word;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int words_sent  = 0;

  // Idle odds in percent per cycle, for the sender and the receiver.
  int tx_idle_pct = 20;
  int rx_idle_pct = 76;

  // Mirror of what was last written, so frames use the live marker and
  // tick bursts can be sized against the live timeout.
  logic [7:0] cur_marker  = MarkerReset;
  int         cur_timeout = TimeoutReset;

  xor_checksum_packet_deframer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  deframer_checker frame_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_word_i    (out_word),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: ready is re-rolled every cycle at the current idle odds.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // One input word: optional idle gap first, then hold valid until taken.
  // Valid is left high on return so back-to-back words keep it asserted.
  task automatic send_word(input logic func, input logic [7:0] value);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_word <= '{func: func, rx_byte: value};
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Byte inside a frame, sometimes preceded by a tick or two. Only done when
  // the timeout is long enough that these ticks can never expire it.
  task automatic frame_byte(input logic [7:0] value);
    if (cur_timeout >= 4 && $urandom_range(9) == 0)
      repeat ($urandom_range(1, 2)) send_word(1'b1, 8'($urandom));
    send_word(1'b0, value);
  endtask

  // Full frame with random payload. Lengths above the buffer stop after the
  // length byte, since the block restarts there.
  task automatic send_frame(input int len, input bit good);
    logic [7:0] sum;
    logic [7:0] value;
    sum = len[7:0];
    frame_byte(cur_marker);
    frame_byte(len[7:0]);
    if (len > MaxPayload) return;
    for (int i = 0; i < len; i++) begin
      value = 8'($urandom);
      sum ^= value;
      frame_byte(value);
    end
    // flip one bit for a checksum error
    if (!good) sum ^= 8'(1 << $urandom_range(7));
    frame_byte(sum);
  endtask

  // Mostly short payloads, with a full buffer now and then and some empties.
  function automatic int frame_length();
    case ($urandom_range(19))
      0:       return 0;
      1, 2:    return MaxPayload;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Both registers per call; we stays high across the two writes.
  task automatic set_config(input logic [7:0] marker, input logic [TicksW-1:0] ticks);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_START_MARKER;
    // upper bits are junk on purpose: only the low byte is the marker
    cfg_data <= {9'($urandom), marker};
    @(posedge clk);
    cfg_idx <= CFG_TIMEOUT;
    cfg_data <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_marker = marker;
    cur_timeout = ticks;
  endtask

  // Quiesce: drop valid, let every expected word drain, then wait out DrainWait
  // for a word that causes no result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Random traffic: mostly well-formed frames, with bad checksums, oversize
  // lengths, stray bytes, tick bursts and truncated frames mixed in.
  task automatic run_random(input int count);
    int stop_at;
    int kind;
    int len;
    int burst;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 65) begin
        send_frame(frame_length(), 1'b1);
      end else if (kind < 77) begin
        send_frame(frame_length(), 1'b0);
      end else if (kind < 83) begin
        send_frame(($urandom_range(3) == 0) ? MaxPayload + 1
                                            : $urandom_range(MaxPayload + 1, 255), 1'b1);
      end else if (kind < 89) begin
        // stray byte; if it happens to match the marker a frame just starts
        send_word(1'b0, 8'($urandom));
      end else if (kind < 95) begin
        burst = (cur_timeout < 8) ? $urandom_range(1, cur_timeout + 2) : $urandom_range(1, 4);
        repeat (burst) send_word(1'b1, 8'($urandom));
      end else begin
        // frame cut short, then silence until it times out
        len = $urandom_range(2, 8);
        frame_byte(cur_marker);
        frame_byte(8'(len));
        repeat ($urandom_range(len - 1)) frame_byte(8'($urandom));
        if (cur_timeout <= 16) repeat (cur_timeout + 1) send_word(1'b1, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words, default marker and a 3-tick timeout. ticks_left still
    // holds the reset load until the first byte arrives.
    set_config(MarkerReset, 17'd3);
    send_word(1'b1, 8'hFF);                 // tick far from timeout, byte ignored
    send_word(1'b0, 8'h00);                 // wrong start byte, also reloads to 3
    repeat (3) send_word(1'b1, 8'h00);      // third tick times out while idle
    send_word(1'b0, MarkerReset);           // empty packet, checksum 0
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'h00);
    send_word(1'b0, MarkerReset);           // one past the buffer size
    send_word(1'b0, 8'd33);
    send_word(1'b0, MarkerReset);           // largest length byte
    send_word(1'b0, 8'hFF);
    send_word(1'b0, MarkerReset);           // one-byte packet, all ones
    send_word(1'b0, 8'h01);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'hFE);
    send_word(1'b0, MarkerReset);           // checksum mismatch (good would be 58)
    send_word(1'b0, 8'h02);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'h5A);
    send_word(1'b0, 8'hA7);
    send_word(1'b0, MarkerReset);           // timeout in the middle of a payload
    send_word(1'b0, 8'h03);
    send_word(1'b0, 8'h11);
    repeat (3) send_word(1'b1, 8'hFF);
    wait_idle();

    // Sender idles lightly, receiver heavily; all-zero marker.
    set_config(8'h00, 17'd5);
    run_random(100);
    wait_idle();

    // Roles swapped; all-ones marker and a zero timeout (every tick expires).
    tx_idle_pct = 76;
    rx_idle_pct = 20;
    set_config(8'hFF, 17'd0);
    run_random(100);
    wait_idle();

    // No idling from here on; longest timeout, which never expires after its first reload.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(8'($urandom), 17'h1FFFF);
    run_random(100);
    wait_idle();

    // Timeout of one tick with a random marker.
    set_config(8'($urandom), 17'd1);
    run_random(100);
    wait_idle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
